[hdl/softened_gravity_leapfrog_particle_assert.svh]
// Assertion helpers shared by the RTL files.
`ifndef SOFTENED_GRAVITY_LEAPFROG_PARTICLE_ASSERT_SVH
`define SOFTENED_GRAVITY_LEAPFROG_PARTICLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGLP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sglp_pkg.sv]
package sglp_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int GRAV_FRAC = 24;
    localparam int DIV_SHIFT = 2 * FRAC_W - GRAV_FRAC;
    localparam int ADDR_W    = 4;

    // Shared unit operand and result widths, counter width and step counts
    localparam int ALU_A_W    = 104;
    localparam int ALU_B_W    = 99;
    localparam int MUL_HALF   = 33;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = 33;
    localparam int DIV_STEPS  = 34;

    localparam logic [31:0] RST_TIME_STEP = 32'd655;
    localparam logic [31:0] RST_GRAVITY   = 32'd16777216;
    localparam logic [31:0] RST_SOFTENING = 32'd655;

    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_CLEAR_ACC  = 3'd1,
        OP_ADD_PULL   = 3'd2,
        OP_HALF_DRIFT = 3'd3,
        OP_KICK_DRIFT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_GRAVITY   = 2'd1,
        REG_SOFTENING = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_SQRT,
        ALU_DIV
    } t_alu_mode;

    typedef struct packed {
        t_alu_mode            mode;
        logic [ALU_A_W-1:0]   a;
        logic [ALU_B_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] time_step;
        logic [31:0] gravity_constant;
        logic [31:0] softening_length;
    } t_cfg;

    typedef struct packed {
        logic        sat;
        logic [31:0] value;
    } t_sat_res;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // Signed word plus a sign/magnitude term, clipped to the word range.
    function automatic t_sat_res sat_add(input logic [31:0] a, input logic bneg,
                                         input logic [47:0] bmag);
        logic [35:0] a36;
        logic [35:0] m36;
        logic [35:0] sum;
        logic        big;
        logic        ovf;
        t_sat_res    r;
        a36 = {{4{a[31]}}, a};
        m36 = {3'b0, bmag[32:0]};
        sum = bneg ? (a36 - m36) : (a36 + m36);
        big = |bmag[47:33];
        ovf = !((&sum[35:31]) || !(|sum[35:31]));
        if (big) begin
            r.sat   = 1'b1;
            r.value = bneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (ovf) begin
            r.sat   = 1'b1;
            r.value = sum[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r.sat   = 1'b0;
            r.value = sum[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/sglp_in_if.sv]
interface sglp_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic [31:0]        src_mass;
    logic signed [31:0] load_px;
    logic signed [31:0] load_py;
    logic signed [31:0] load_vx;
    logic signed [31:0] load_vy;

    modport source (output valid, op, src_x, src_y, src_mass, load_px, load_py,
                    load_vx, load_vy, input ready);
    modport sink (input valid, op, src_x, src_y, src_mass, load_px, load_py,
                  load_vx, load_vy, output ready);
endinterface

[hdl/sglp_out_if.sv]
interface sglp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_acc_x;
    logic signed [31:0] out_acc_y;
    logic               saturated;

    modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                    out_acc_x, out_acc_y, saturated, input ready);
    modport sink (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                  out_acc_x, out_acc_y, saturated, output ready);
endinterface

[hdl/sglp_cfg.sv]
module sglp_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sglp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sglp_pkg::t_cfg               o_cfg
);

    sglp_pkg::t_cfg r_cfg;
    sglp_pkg::t_cfg n_cfg;
    logic           w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (paddr[3:2])
                sglp_pkg::REG_TIME_STEP: n_cfg.time_step        = pwdata;
                sglp_pkg::REG_GRAVITY:   n_cfg.gravity_constant = pwdata;
                sglp_pkg::REG_SOFTENING: n_cfg.softening_length = pwdata;
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sglp_pkg::REG_TIME_STEP: prdata = r_cfg.time_step;
            sglp_pkg::REG_GRAVITY:   prdata = r_cfg.gravity_constant;
            sglp_pkg::REG_SOFTENING: prdata = r_cfg.softening_length;
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step        <= sglp_pkg::RST_TIME_STEP;
            r_cfg.gravity_constant <= sglp_pkg::RST_GRAVITY;
            r_cfg.softening_length <= sglp_pkg::RST_SOFTENING;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hdl/sglp_alu.sv]
`include "softened_gravity_leapfrog_particle_assert.svh"

module sglp_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  sglp_pkg::t_alu_req            i_req,
    output logic                          o_done,
    output logic [sglp_pkg::ALU_A_W-1:0]  o_res
);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SQRT, ST_DIV} t_state;

    t_state                          r_state, n_state;
    logic [sglp_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                            r_done, n_done;
    logic [65:0]                     r_a, n_a;
    logic [32:0]                     r_b, n_b;
    logic [65:0]                     r_pp, n_pp;
    logic [103:0]                    r_acc, n_acc;
    logic [103:0]                    r_rem, n_rem;
    logic [131:0]                    r_dv, n_dv;

    logic [32:0]                     w_mul_a;
    logic [65:0]                     w_prod;
    logic [65:0]                     w_sq_t;
    logic                            w_sq_ge;
    logic                            w_div_ge;

    // One 33x33 multiplier serves both halves of a wide operand
    assign w_mul_a  = (r_cnt == '0) ? r_a[32:0] : r_a[65:33];
    assign w_prod   = w_mul_a * r_b;
    assign w_sq_t   = r_acc[65:0] + r_dv[65:0];
    assign w_sq_ge  = r_rem[65:0] >= w_sq_t;
    assign w_div_ge = {28'b0, r_rem} >= r_dv;

    assign o_done = r_done;
    assign o_res  = r_acc;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_a     = r_a;
        n_b     = r_b;
        n_pp    = r_pp;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_dv    = r_dv;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_cnt = '0;
                    unique case (i_req.mode)
                        sglp_pkg::ALU_MUL: begin
                            n_a     = i_req.a[65:0];
                            n_b     = i_req.b[32:0];
                            n_state = ST_MUL;
                        end
                        sglp_pkg::ALU_SQRT: begin
                            n_rem   = {38'b0, i_req.a[65:0]};
                            n_acc   = '0;
                            n_dv    = {67'b0, 1'b1, 64'b0};
                            n_state = ST_SQRT;
                        end
                        sglp_pkg::ALU_DIV: begin
                            n_rem   = i_req.a;
                            n_acc   = '0;
                            n_dv    = {i_req.b, 33'b0};
                            n_state = ST_DIV;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: begin
                n_cnt = r_cnt + 1'b1;
                n_pp  = w_prod;
                if (r_cnt == 6'd1) begin
                    n_acc = {38'b0, r_pp};
                end else if (r_cnt == 6'd2) begin
                    n_acc   = r_acc + {5'b0, r_pp, 33'b0};
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SQRT: begin
                // One result bit per cycle, digit-by-digit floor root
                n_cnt = r_cnt + 1'b1;
                if (w_sq_ge) begin
                    n_rem = {38'b0, r_rem[65:0] - w_sq_t};
                    n_acc = {38'b0, (r_acc[65:0] >> 1) + r_dv[65:0]};
                end else begin
                    n_acc = {38'b0, r_acc[65:0] >> 1};
                end
                n_dv = r_dv >> 2;
                if (r_cnt == 6'(sglp_pkg::SQRT_STEPS - 1)) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                // Restoring division; the top quotient bit flags a too-large result
                n_cnt = r_cnt + 1'b1;
                if (w_div_ge) begin
                    n_rem = r_rem - r_dv[103:0];
                end
                n_acc = {r_acc[102:0], w_div_ge};
                n_dv  = r_dv >> 1;
                if (r_cnt == 6'(sglp_pkg::DIV_STEPS - 1)) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_a     <= n_a;
            r_b     <= n_b;
            r_pp    <= n_pp;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_dv    <= n_dv;
        end
    end

    `SGLP_ASSERT_NOW(a_start_idle, i_clk, i_rst_n, i_start, r_state == ST_IDLE, "start while busy")
    `SGLP_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done held two cycles")
    `SGLP_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_state != ST_IDLE, "start ignored")

endmodule

[hdl/softened_gravity_leapfrog_particle.sv]
// Softened-gravity leapfrog particle, 2-D, Q16.16 fixed point.
// i_item (valid/ready) takes one word: an op and its operands. Each word
// yields exactly one result word on o_result: the full particle state
// (position, velocity, acceleration) and a flag set when any value clipped.
// The APB port holds dt, G and the softening length; write it only while
// the block is idle. pready is tied high.
// A single shared unit (33x33 multiplier, one-bit-per-cycle root and
// divider) does all multiplies, roots and divides under the sequencer
// below, one word at a time. A pull with r < eps adds a second root, of
// r^2 + eps^2, to the root and the two per-axis divides of a pull.
// A finished result sits in an output register; the next word is accepted
// while it waits, but a new result is not written over one that o_result
// has not taken, so a stalled receiver holds the sequencer in its last state.
// Reset clears the particle state to zero and loads the register defaults.
`include "softened_gravity_leapfrog_particle_assert.svh"

module softened_gravity_leapfrog_particle (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sglp_in_if.sink                      i_item,
    sglp_out_if.source                   o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sglp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH, ST_KICK_X, ST_KICK_Y, ST_DRIFT_X, ST_DRIFT_Y,
        ST_SQ_X, ST_SQ_Y, ST_ROOT, ST_R2, ST_EPS2, ST_SROOT, ST_DEN_NEAR,
        ST_DEN_FAR, ST_GM, ST_NUM_X, ST_DIV_X, ST_NUM_Y, ST_DIV_Y, ST_EMIT
    } t_state;

    sglp_pkg::t_cfg      w_cfg;
    sglp_pkg::t_alu_req  w_req;
    logic                w_start;
    logic                w_alu_done;
    logic [103:0]        w_alu_res;

    t_state       r_state, n_state;
    logic         r_issued, n_issued;
    logic [2:0]   r_op, n_op;
    logic [31:0]  r_sx, n_sx;
    logic [31:0]  r_sy, n_sy;
    logic [31:0]  r_mass, n_mass;
    logic [31:0]  r_x, n_x;
    logic [31:0]  r_y, n_y;
    logic [31:0]  r_vx, n_vx;
    logic [31:0]  r_vy, n_vy;
    logic [31:0]  r_ax, n_ax;
    logic [31:0]  r_ay, n_ay;
    logic         r_sat, n_sat;
    logic         r_xneg, n_xneg;
    logic         r_yneg, n_yneg;
    logic [31:0]  r_xm, n_xm;
    logic [31:0]  r_ym, n_ym;
    logic [65:0]  r_w, n_w;
    logic [32:0]  r_r, n_r;
    logic         r_near, n_near;
    logic [98:0]  r_den, n_den;
    logic [63:0]  r_gm, n_gm;
    logic [95:0]  r_num, n_num;
    logic         r_out_valid, n_out_valid;
    logic [31:0]  r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_ax, r_o_ay;
    logic [31:0]  n_o_px, n_o_py, n_o_vx, n_o_vy, n_o_ax, n_o_ay;
    logic         r_o_sat, n_o_sat;

    logic [32:0]  w_dx;
    logic [32:0]  w_dy;
    logic [31:0]  w_add_a;
    logic         w_add_neg;
    logic [47:0]  w_add_mag;
    sglp_pkg::t_sat_res w_add;
    logic         w_compute;

    sglp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sglp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_alu_done),
        .o_res   (w_alu_res)
    );

    assign i_item.ready       = (r_state == ST_IDLE);
    assign o_result.valid     = r_out_valid;
    assign o_result.out_pos_x = r_o_px;
    assign o_result.out_pos_y = r_o_py;
    assign o_result.out_vel_x = r_o_vx;
    assign o_result.out_vel_y = r_o_vy;
    assign o_result.out_acc_x = r_o_ax;
    assign o_result.out_acc_y = r_o_ay;
    assign o_result.saturated = r_o_sat;

    // Own position minus source position, one bit wider than a word
    assign w_dx = {r_x[31], r_x} - {r_sx[31], r_sx};
    assign w_dy = {r_y[31], r_y} - {r_sy[31], r_sy};

    assign w_compute = !(r_state == ST_IDLE || r_state == ST_DISPATCH ||
                         r_state == ST_EMIT);
    assign w_start   = w_compute && !r_issued;

    // Operands for the shared unit in each compute step
    always_comb begin
        w_req.mode = sglp_pkg::ALU_MUL;
        w_req.a    = '0;
        w_req.b    = '0;
        case (r_state)
            ST_KICK_X: begin
                w_req.a = {72'b0, w_cfg.time_step};
                w_req.b = {67'b0, sglp_pkg::mag32(r_ax)};
            end
            ST_KICK_Y: begin
                w_req.a = {72'b0, w_cfg.time_step};
                w_req.b = {67'b0, sglp_pkg::mag32(r_ay)};
            end
            ST_DRIFT_X: begin
                w_req.a = {72'b0, w_cfg.time_step};
                w_req.b = {67'b0, sglp_pkg::mag32(r_vx)};
            end
            ST_DRIFT_Y: begin
                w_req.a = {72'b0, w_cfg.time_step};
                w_req.b = {67'b0, sglp_pkg::mag32(r_vy)};
            end
            ST_SQ_X: begin
                w_req.a = {72'b0, r_xm};
                w_req.b = {67'b0, r_xm};
            end
            ST_SQ_Y: begin
                w_req.a = {72'b0, r_ym};
                w_req.b = {67'b0, r_ym};
            end
            ST_ROOT, ST_SROOT: begin
                w_req.mode = sglp_pkg::ALU_SQRT;
                w_req.a    = {38'b0, r_w};
            end
            ST_R2: begin
                w_req.a = {71'b0, r_r};
                w_req.b = {66'b0, r_r};
            end
            ST_EPS2: begin
                w_req.a = {72'b0, w_cfg.softening_length};
                w_req.b = {67'b0, w_cfg.softening_length};
            end
            ST_DEN_NEAR, ST_DEN_FAR: begin
                w_req.a = {38'b0, r_w};
                w_req.b = {66'b0, r_r};
            end
            ST_GM: begin
                w_req.a = {72'b0, w_cfg.gravity_constant};
                w_req.b = {67'b0, r_mass};
            end
            ST_NUM_X: begin
                w_req.a = {40'b0, r_gm};
                w_req.b = {67'b0, r_xm};
            end
            ST_NUM_Y: begin
                w_req.a = {40'b0, r_gm};
                w_req.b = {67'b0, r_ym};
            end
            ST_DIV_X, ST_DIV_Y: begin
                // Numerator scaled by 2^(2*FRAC_W-GRAV_FRAC) = 2^8
                w_req.mode = sglp_pkg::ALU_DIV;
                w_req.a    = {r_num, 8'b0};
                w_req.b    = r_den;
            end
            default: w_req.mode = sglp_pkg::ALU_MUL;
        endcase
    end

    // Saturating add shared by kick, drift and pull
    always_comb begin
        w_add_a   = r_x;
        w_add_neg = 1'b0;
        w_add_mag = '0;
        case (r_state)
            ST_KICK_X: begin
                w_add_a   = r_vx;
                w_add_neg = r_ax[31];
                w_add_mag = w_alu_res[63:16];
            end
            ST_KICK_Y: begin
                w_add_a   = r_vy;
                w_add_neg = r_ay[31];
                w_add_mag = w_alu_res[63:16];
            end
            ST_DRIFT_X: begin
                w_add_a   = r_x;
                w_add_neg = r_vx[31];
                w_add_mag = {1'b0, w_alu_res[63:17]};
            end
            ST_DRIFT_Y: begin
                w_add_a   = r_y;
                w_add_neg = r_vy[31];
                w_add_mag = {1'b0, w_alu_res[63:17]};
            end
            ST_DIV_X: begin
                // Pull points toward the source
                w_add_a   = r_ax;
                w_add_neg = !r_xneg;
                w_add_mag = {14'b0, w_alu_res[33:0]};
            end
            ST_DIV_Y: begin
                w_add_a   = r_ay;
                w_add_neg = !r_yneg;
                w_add_mag = {14'b0, w_alu_res[33:0]};
            end
            default: w_add_mag = '0;
        endcase
    end

    assign w_add = sglp_pkg::sat_add(w_add_a, w_add_neg, w_add_mag);

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_op        = r_op;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_mass      = r_mass;
        n_x         = r_x;
        n_y         = r_y;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_sat       = r_sat;
        n_xneg      = r_xneg;
        n_yneg      = r_yneg;
        n_xm        = r_xm;
        n_ym        = r_ym;
        n_w         = r_w;
        n_r         = r_r;
        n_near      = r_near;
        n_den       = r_den;
        n_gm        = r_gm;
        n_num       = r_num;
        n_o_px      = r_o_px;
        n_o_py      = r_o_py;
        n_o_vx      = r_o_vx;
        n_o_vy      = r_o_vy;
        n_o_ax      = r_o_ax;
        n_o_ay      = r_o_ay;
        n_o_sat     = r_o_sat;
        n_out_valid = r_out_valid && !o_result.ready;

        if (w_start) begin
            n_issued = 1'b1;
        end
        if (w_alu_done) begin
            n_issued = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_op    = i_item.op;
                    n_sx    = i_item.src_x;
                    n_sy    = i_item.src_y;
                    n_mass  = i_item.src_mass;
                    n_sat   = 1'b0;
                    n_state = ST_DISPATCH;
                    if (i_item.op == sglp_pkg::OP_LOAD) begin
                        n_x  = i_item.load_px;
                        n_y  = i_item.load_py;
                        n_vx = i_item.load_vx;
                        n_vy = i_item.load_vy;
                    end
                end
            end
            ST_DISPATCH: begin
                case (r_op)
                    sglp_pkg::OP_CLEAR_ACC: begin
                        n_ax    = '0;
                        n_ay    = '0;
                        n_state = ST_EMIT;
                    end
                    sglp_pkg::OP_ADD_PULL: begin
                        n_xneg  = w_dx[32];
                        n_yneg  = w_dy[32];
                        n_xm    = w_dx[32] ? 32'(-w_dx) : w_dx[31:0];
                        n_ym    = w_dy[32] ? 32'(-w_dy) : w_dy[31:0];
                        n_state = ST_SQ_X;
                    end
                    sglp_pkg::OP_HALF_DRIFT: n_state = ST_DRIFT_X;
                    sglp_pkg::OP_KICK_DRIFT: n_state = ST_KICK_X;
                    default:                 n_state = ST_EMIT;
                endcase
            end
            ST_KICK_X: if (w_alu_done) begin
                n_vx    = w_add.value;
                n_sat   = r_sat | w_add.sat;
                n_state = ST_KICK_Y;
            end
            ST_KICK_Y: if (w_alu_done) begin
                n_vy    = w_add.value;
                n_sat   = r_sat | w_add.sat;
                n_state = ST_DRIFT_X;
            end
            ST_DRIFT_X: if (w_alu_done) begin
                n_x     = w_add.value;
                n_sat   = r_sat | w_add.sat;
                n_state = ST_DRIFT_Y;
            end
            ST_DRIFT_Y: if (w_alu_done) begin
                n_y     = w_add.value;
                n_sat   = r_sat | w_add.sat;
                n_state = ST_EMIT;
            end
            ST_SQ_X: if (w_alu_done) begin
                n_w     = w_alu_res[65:0];
                n_state = ST_SQ_Y;
            end
            ST_SQ_Y: if (w_alu_done) begin
                n_w     = r_w + w_alu_res[65:0];
                n_state = ST_ROOT;
            end
            ST_ROOT: if (w_alu_done) begin
                n_r     = w_alu_res[32:0];
                n_near  = w_alu_res[32:0] < {1'b0, w_cfg.softening_length};
                n_state = ST_R2;
            end
            ST_R2: if (w_alu_done) begin
                n_w     = w_alu_res[65:0];
                n_state = r_near ? ST_EPS2 : ST_DEN_FAR;
            end
            ST_EPS2: if (w_alu_done) begin
                // Inside the softening length: s = r^2 + eps^2
                n_w     = r_w + w_alu_res[65:0];
                n_state = ST_SROOT;
            end
            ST_SROOT: if (w_alu_done) begin
                n_r     = w_alu_res[32:0];
                n_state = ST_DEN_NEAR;
            end
            ST_DEN_NEAR, ST_DEN_FAR: if (w_alu_done) begin
                // Coincident particles with no softening: drop the pull
                n_den   = w_alu_res[98:0];
                n_state = (w_alu_res[98:0] == '0) ? ST_EMIT : ST_GM;
            end
            ST_GM: if (w_alu_done) begin
                n_gm    = w_alu_res[63:0];
                n_state = ST_NUM_X;
            end
            ST_NUM_X: if (w_alu_done) begin
                n_num   = w_alu_res[95:0];
                n_state = ST_DIV_X;
            end
            ST_DIV_X: if (w_alu_done) begin
                n_ax    = w_add.value;
                n_sat   = r_sat | w_add.sat;
                n_state = ST_NUM_Y;
            end
            ST_NUM_Y: if (w_alu_done) begin
                n_num   = w_alu_res[95:0];
                n_state = ST_DIV_Y;
            end
            ST_DIV_Y: if (w_alu_done) begin
                n_ay    = w_add.value;
                n_sat   = r_sat | w_add.sat;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_o_px      = r_x;
                    n_o_py      = r_y;
                    n_o_vx      = r_vx;
                    n_o_vy      = r_vy;
                    n_o_ax      = r_ax;
                    n_o_ay      = r_ay;
                    n_o_sat     = r_sat;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_sat       <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_ax        <= '0;
            r_ay        <= '0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_sat       <= n_sat;
            r_x         <= n_x;
            r_y         <= n_y;
            r_vx        <= n_vx;
            r_vy        <= n_vy;
            r_ax        <= n_ax;
            r_ay        <= n_ay;
            r_op        <= n_op;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_mass      <= n_mass;
            r_xneg      <= n_xneg;
            r_yneg      <= n_yneg;
            r_xm        <= n_xm;
            r_ym        <= n_ym;
            r_w         <= n_w;
            r_r         <= n_r;
            r_near      <= n_near;
            r_den       <= n_den;
            r_gm        <= n_gm;
            r_num       <= n_num;
            r_o_px      <= n_o_px;
            r_o_py      <= n_o_py;
            r_o_vx      <= n_o_vx;
            r_o_vy      <= n_o_vy;
            r_o_ax      <= n_o_ax;
            r_o_ay      <= n_o_ay;
            r_o_sat     <= n_o_sat;
        end
    end

    `SGLP_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, i_item.valid && i_item.ready, r_state == ST_DISPATCH, "accept did not dispatch")
    `SGLP_ASSERT_NOW(a_done_in_step, i_clk, i_rst_n, w_alu_done, w_compute && r_issued, "unit result outside a compute step")
    `SGLP_ASSERT_NOW(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_EMIT, "result loaded outside emit")

endmodule
